[hdl/aegc_pkg.sv]
// ----------------------------------------------------------------------------
// aegc_pkg
// Types and character constants for the Accept-Encoding gzip checker.
// ----------------------------------------------------------------------------
package aegc_pkg;

    // Parser phase, one-hot
    typedef enum logic [11:0] {
        PH_BETWEEN    = 12'b0000_0000_0001,
        PH_TOKEN      = 12'b0000_0000_0010,
        PH_AFTER      = 12'b0000_0000_0100,
        PH_PNAME_PRE  = 12'b0000_0000_1000,
        PH_PNAME      = 12'b0000_0001_0000,
        PH_PNAME_POST = 12'b0000_0010_0000,
        PH_VALUE_PRE  = 12'b0000_0100_0000,
        PH_Q_WHOLE    = 12'b0000_1000_0000,
        PH_Q_FRAC     = 12'b0001_0000_0000,
        PH_QSTR       = 12'b0010_0000_0000,
        PH_QESC       = 12'b0100_0000_0000,
        PH_VTOKEN     = 12'b1000_0000_0000
    } t_phase;

    localparam logic [7:0] C_TAB    = 8'h09;
    localparam logic [7:0] C_SPACE  = 8'h20;
    localparam logic [7:0] C_DQUOTE = 8'h22;
    localparam logic [7:0] C_STAR   = 8'h2A;
    localparam logic [7:0] C_COMMA  = 8'h2C;
    localparam logic [7:0] C_DOT    = 8'h2E;
    localparam logic [7:0] C_ZERO   = 8'h30;
    localparam logic [7:0] C_ONE    = 8'h31;
    localparam logic [7:0] C_NINE   = 8'h39;
    localparam logic [7:0] C_SEMI   = 8'h3B;
    localparam logic [7:0] C_EQUALS = 8'h3D;
    localparam logic [7:0] C_BSLASH = 8'h5C;
    localparam logic [7:0] C_LOW_Q  = 8'h71;

    localparam logic [9:0]  W_FULL  = 10'd1000;
    localparam logic [10:0] W_LIMIT = 11'd1000;
    localparam logic [2:0]  TOK_MAX = 3'd7;
    localparam logic [2:0]  TOK_GZ  = 3'd4;

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A) begin
            r = c + 8'd32;
        end
        return r;
    endfunction

    // Lower-case letters of the coding name, by position
    function automatic logic [7:0] word_char(input logic [1:0] idx);
        logic [7:0] r;
        case (idx)
            2'd0:    r = 8'h67;
            2'd1:    r = 8'h7A;
            2'd2:    r = 8'h69;
            default: r = 8'h70;
        endcase
        return r;
    endfunction

    function automatic logic is_tchar(input logic [7:0] c);
        logic r;
        r = (c inside {[8'h61:8'h7A], [8'h41:8'h5A], [8'h30:8'h39]}) ||
            (c inside {8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2A, 8'h2B,
                       8'h2D, 8'h2E, 8'h5E, 8'h5F, 8'h60, 8'h7C, 8'h7E});
        return r;
    endfunction

endpackage

[hdl/accept_encoding_gzip_check_top.sv]
// ----------------------------------------------------------------------------
// accept_encoding_gzip_check_top
// Streams an Accept-Encoding header and reports whether gzip may be sent.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (i_in_valid / o_in_ready): one word per header byte with
//   i_action = 0, then one word with i_action = 1 to close the header. An
//   absent header is sent as the end word alone.
//   Output channel (o_out_valid / i_out_ready): exactly one word per end
//   word, o_gzip_accepted = 1 when gzip is acceptable (named gzip beats a
//   star, q=0 refuses, malformed or unmentioned gives 0).
//   Path: a word is held in the input register and parsed from there; the
//   result of an end word is registered in the result register and then
//   driven on o_out_valid / o_gzip_accepted.
//   Throughput: one word per cycle unless an end word waits on an untaken
//   result; set by the single parse step from input to state/result registers.
//   Stall: byte words never wait on the output. An end word waits in the input
//   register while an untaken result is still held; the input channel then
//   takes nothing more until the result is taken.
//   Reset: synchronous, active low; clears both channels and the parse state.
//   After each end word the parser returns to its reset state by itself.
// ----------------------------------------------------------------------------
module accept_encoding_gzip_check_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic       i_action,
    input  logic [7:0] i_header_byte,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_gzip_accepted
);
    import aegc_pkg::*;

    // input register
    logic       r_in_valid;
    logic       r_action;
    logic [7:0] r_byte;

    // parse state
    t_phase     r_phase,    n_phase;
    logic [2:0] r_tok_len,  n_tok_len;
    logic       r_match,    n_match;
    logic       r_star,     n_star;
    logic [9:0] r_weight,   n_weight;
    logic [1:0] r_qdig,     n_qdig;
    logic [1:0] r_pn_len,   n_pn_len;
    logic       r_is_q,     n_is_q;
    logic       r_gz_seen,  n_gz_seen;   // gzip mentioned
    logic       r_gz_ok,    n_gz_ok;     // ... with weight above zero
    logic       r_st_seen,  n_st_seen;
    logic       r_st_ok,    n_st_ok;
    logic       r_failed,   n_failed;

    // result register
    logic       r_out_valid;
    logic       r_gzip;

    logic        proc;
    logic        c_blank;
    logic        c_tchar;
    logic        c_digit;
    logic [7:0]  c_low;
    logic        to_after;
    logic        commit_gz;
    logic        commit_st;
    logic [10:0] frac_add;
    logic [10:0] frac_sum;
    logic        end_fail;
    logic        end_commit;
    logic        result;

    // end words need a free result slot, byte words never wait
    assign proc       = r_in_valid && (!r_action || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || proc;

    assign c_blank = (r_byte == C_SPACE) || (r_byte == C_TAB);
    assign c_digit = (r_byte >= C_ZERO) && (r_byte <= C_NINE);
    assign c_tchar = is_tchar(r_byte);
    assign c_low   = to_lower(r_byte);

    // element closes with the current token fields and weight
    assign commit_gz = r_match && (r_tok_len == TOK_GZ);
    assign commit_st = !commit_gz && r_star && (r_tok_len == 3'd1);

    // next fractional digit of q, scaled by its position
    always_comb begin
        case (r_qdig)
            2'd0:    frac_add = 11'(r_byte[3:0]) * 11'd100;
            2'd1:    frac_add = 11'(r_byte[3:0]) * 11'd10;
            default: frac_add = 11'(r_byte[3:0]);
        endcase
    end
    assign frac_sum = {1'b0, r_weight} + frac_add;

    // end-of-header check
    always_comb begin
        end_fail   = 1'b0;
        end_commit = 1'b0;
        case (r_phase)
            PH_BETWEEN: ;
            PH_TOKEN, PH_AFTER, PH_Q_WHOLE, PH_VTOKEN: end_commit = 1'b1;
            PH_Q_FRAC: begin
                if (r_qdig == 2'd0) begin
                    end_fail = 1'b1;
                end else begin
                    end_commit = 1'b1;
                end
            end
            default: end_fail = 1'b1;
        endcase
    end

    always_comb begin
        if (r_failed || end_fail) begin
            result = 1'b0;
        end else if ((end_commit && commit_gz) || r_gz_seen) begin
            result = (end_commit && commit_gz) ? (r_weight != 10'd0) : r_gz_ok;
        end else if (end_commit && commit_st) begin
            result = (r_weight != 10'd0);
        end else begin
            result = r_st_seen && r_st_ok;
        end
    end

    // one byte step
    always_comb begin
        n_phase   = r_phase;
        n_tok_len = r_tok_len;
        n_match   = r_match;
        n_star    = r_star;
        n_weight  = r_weight;
        n_qdig    = r_qdig;
        n_pn_len  = r_pn_len;
        n_is_q    = r_is_q;
        n_gz_seen = r_gz_seen;
        n_gz_ok   = r_gz_ok;
        n_st_seen = r_st_seen;
        n_st_ok   = r_st_ok;
        n_failed  = r_failed;
        to_after  = 1'b0;

        if (!r_failed) begin
            case (r_phase)
                PH_BETWEEN: begin
                    if (c_blank || r_byte == C_COMMA) begin
                        n_phase = PH_BETWEEN;
                    end else if (!c_tchar) begin
                        n_failed = 1'b1;
                    end else begin
                        // start a token and take its first character
                        n_weight  = W_FULL;
                        n_tok_len = 3'd1;
                        n_match   = (c_low == word_char(2'd0));
                        n_star    = (r_byte == C_STAR);
                        n_phase   = PH_TOKEN;
                    end
                end
                PH_TOKEN: begin
                    if (c_tchar) begin
                        if (r_tok_len < TOK_GZ && c_low != word_char(r_tok_len[1:0])) begin
                            n_match = 1'b0;
                        end
                        if (r_tok_len < TOK_MAX) begin
                            n_tok_len = r_tok_len + 3'd1;
                        end
                    end else begin
                        to_after = 1'b1;
                    end
                end
                PH_AFTER: to_after = 1'b1;
                PH_PNAME_PRE: begin
                    if (c_blank) begin
                        n_phase = PH_PNAME_PRE;
                    end else if (!c_tchar) begin
                        n_failed = 1'b1;
                    end else begin
                        n_pn_len = 2'd1;
                        n_is_q   = (c_low == C_LOW_Q);
                        n_phase  = PH_PNAME;
                    end
                end
                PH_PNAME, PH_PNAME_POST: begin
                    if (r_phase == PH_PNAME && c_tchar) begin
                        if (r_pn_len < 2'd2) begin
                            n_pn_len = r_pn_len + 2'd1;
                        end
                    end else if (c_blank) begin
                        n_phase = PH_PNAME_POST;
                    end else if (r_byte == C_EQUALS) begin
                        n_phase = PH_VALUE_PRE;
                    end else begin
                        n_failed = 1'b1;
                    end
                end
                PH_VALUE_PRE: begin
                    if (c_blank) begin
                        n_phase = PH_VALUE_PRE;
                    end else if (r_is_q && r_pn_len == 2'd1) begin
                        if (r_byte == C_ZERO || r_byte == C_ONE) begin
                            n_weight = (r_byte == C_ONE) ? W_FULL : 10'd0;
                            n_qdig   = 2'd0;
                            n_phase  = PH_Q_WHOLE;
                        end else begin
                            n_failed = 1'b1;
                        end
                    end else if (r_byte == C_DQUOTE) begin
                        n_phase = PH_QSTR;
                    end else if (c_tchar) begin
                        n_phase = PH_VTOKEN;
                    end else begin
                        n_failed = 1'b1;
                    end
                end
                PH_Q_WHOLE: begin
                    if (r_byte == C_DOT) begin
                        n_qdig  = 2'd0;
                        n_phase = PH_Q_FRAC;
                    end else begin
                        to_after = 1'b1;
                    end
                end
                PH_Q_FRAC: begin
                    if (c_digit) begin
                        if (r_qdig == 2'd3 || frac_sum > W_LIMIT) begin
                            n_failed = 1'b1;
                        end else begin
                            n_weight = frac_sum[9:0];
                            n_qdig   = r_qdig + 2'd1;
                        end
                    end else if (r_qdig == 2'd0) begin
                        n_failed = 1'b1;
                    end else begin
                        to_after = 1'b1;
                    end
                end
                PH_QSTR: begin
                    if (r_byte == C_BSLASH) begin
                        n_phase = PH_QESC;
                    end else if (r_byte == C_DQUOTE) begin
                        n_phase = PH_AFTER;
                    end
                end
                PH_QESC: n_phase = PH_QSTR;
                PH_VTOKEN: begin
                    if (!c_tchar) begin
                        to_after = 1'b1;
                    end
                end
                default: n_failed = 1'b1;
            endcase

            // after a token or value: blanks, ';' or ','
            if (to_after) begin
                if (c_blank) begin
                    n_phase = PH_AFTER;
                end else if (r_byte == C_SEMI) begin
                    n_phase = PH_PNAME_PRE;
                end else if (r_byte == C_COMMA) begin
                    n_phase = PH_BETWEEN;
                    if (commit_gz) begin
                        n_gz_seen = 1'b1;
                        n_gz_ok   = (r_weight != 10'd0);
                    end else if (commit_st) begin
                        n_st_seen = 1'b1;
                        n_st_ok   = (r_weight != 10'd0);
                    end
                end else begin
                    n_failed = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
        if (o_in_ready && i_in_valid) begin
            r_action <= i_action;
            r_byte   <= i_header_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (proc && r_action)) begin
            r_phase   <= PH_BETWEEN;
            r_tok_len <= 3'd0;
            r_match   <= 1'b0;
            r_star    <= 1'b0;
            r_weight  <= W_FULL;
            r_qdig    <= 2'd0;
            r_pn_len  <= 2'd0;
            r_is_q    <= 1'b0;
            r_gz_seen <= 1'b0;
            r_gz_ok   <= 1'b0;
            r_st_seen <= 1'b0;
            r_st_ok   <= 1'b0;
            r_failed  <= 1'b0;
        end else if (proc) begin
            r_phase   <= n_phase;
            r_tok_len <= n_tok_len;
            r_match   <= n_match;
            r_star    <= n_star;
            r_weight  <= n_weight;
            r_qdig    <= n_qdig;
            r_pn_len  <= n_pn_len;
            r_is_q    <= n_is_q;
            r_gz_seen <= n_gz_seen;
            r_gz_ok   <= n_gz_ok;
            r_st_seen <= n_st_seen;
            r_st_ok   <= n_st_ok;
            r_failed  <= n_failed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc && r_action) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (proc && r_action) begin
            r_gzip <= result;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_gzip_accepted = r_gzip;

endmodule
